@@ rtl/velocity_command_limiter_unit_assert.svh @@
// assertion macros shared by the velocity command limiter checker
`ifndef VELOCITY_COMMAND_LIMITER_UNIT_ASSERT_SVH
`define VELOCITY_COMMAND_LIMITER_UNIT_ASSERT_SVH

// overlapping implication, sampled on aclk, off while reset is low
`define VCL_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("vcl assertion failed");

// next-cycle implication, sampled on aclk, off while reset is low
`define VCL_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("vcl assertion failed");

`endif

@@ rtl/vcl_pkg.sv @@
// types, constants, microcode and helper functions of the velocity command limiter
package vcl_pkg;

    localparam int S_DATA_W   = 160;
    localparam int M_DATA_W   = 96;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;
    localparam int VEL_W      = 32;
    localparam int ROT_W      = 16;
    localparam int AGE_W      = 17;
    localparam int TMO_W      = 16;
    localparam int PC_W       = 4;
    localparam int CNT_W      = 5;

    localparam logic [CFG_DATA_W-1:0] MAX_LIN_RESET = 31'd65536;
    localparam logic [CFG_DATA_W-1:0] MAX_YAW_RESET = 31'd65536;
    localparam logic [TMO_W-1:0]      TIMEOUT_RESET = 16'd500;

    // register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_LIN = 2'd0,
        CFG_MAX_YAW = 2'd1,
        CFG_TIMEOUT = 2'd2
    } cfg_idx_t;

    // request kind carried in s_tuser
    localparam logic ACT_COMMAND = 1'b0;
    localparam logic ACT_TICK    = 1'b1;

    // multiplier operand selection
    typedef enum logic [3:0] {
        MS_NONE,
        MS_VX2,
        MS_VY2,
        MS_LL,
        MS_VXL,
        MS_VYL,
        MS_RXX,
        MS_RXY,
        MS_RYX,
        MS_RYY
    } mul_sel_t;

    // accumulator operation
    typedef enum logic [1:0] {
        SO_HOLD,
        SO_LOAD,
        SO_ADD
    } sum_op_t;

    // step action
    typedef enum logic [2:0] {
        AC_NONE,
        AC_JLE,
        AC_SQRT,
        AC_DIVX,
        AC_DIVY,
        AC_CLIP,
        AC_OUTX,
        AC_OUTY
    } act_t;

    typedef struct packed {
        mul_sel_t          mul_sel;
        sum_op_t           sum_op;
        act_t              act;
        logic [PC_W-1:0]   target;
    } ucode_t;

    localparam logic [PC_W-1:0] PC_ROTATE = 4'd9;

    // control store: one word per step
    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        w = '{mul_sel: MS_NONE, sum_op: SO_HOLD, act: AC_NONE, target: '0};
        unique case (pc)
            4'd0:  w.mul_sel = MS_VX2;
            4'd1:  begin w.mul_sel = MS_VY2; w.sum_op = SO_LOAD; end
            4'd2:  begin w.mul_sel = MS_LL;  w.sum_op = SO_ADD;  end
            4'd3:  begin w.act = AC_JLE; w.target = PC_ROTATE; end
            4'd4:  w.act = AC_SQRT;
            4'd5:  w.mul_sel = MS_VXL;
            4'd6:  w.act = AC_DIVX;
            4'd7:  w.mul_sel = MS_VYL;
            4'd8:  w.act = AC_DIVY;
            4'd9:  begin w.mul_sel = MS_RXX; w.act = AC_CLIP; end
            4'd10: begin w.mul_sel = MS_RXY; w.sum_op = SO_LOAD; end
            4'd11: begin w.mul_sel = MS_RYX; w.sum_op = SO_ADD;  end
            4'd12: begin w.mul_sel = MS_RYY; w.sum_op = SO_LOAD; w.act = AC_OUTX; end
            4'd13: w.sum_op = SO_ADD;
            4'd14: w.act = AC_OUTY;
            default: w.act = AC_NONE;
        endcase
        return w;
    endfunction

    function automatic logic [VEL_W-1:0] mag32(input logic [VEL_W-1:0] v);
        return v[VEL_W-1] ? (~v + 32'd1) : v;
    endfunction

    // Q18.30 sum to Q16.16, round half up, saturate to 32 bits signed
    function automatic logic [VEL_W-1:0] round_sat(input logic [63:0] acc);
        logic [63:0] t;
        logic [49:0] r;
        t = acc + 64'd8192;
        r = t[63:14];
        if ((r[49:31] == '0) || (r[49:31] == '1)) begin
            return r[31:0];
        end else if (r[49]) begin
            return 32'h8000_0000;
        end else begin
            return 32'h7FFF_FFFF;
        end
    endfunction

endpackage

@@ rtl/velocity_command_limiter_unit.sv @@
// velocity command limiter: microcoded sequencer over one multiplier, sqrt and divide units
// a command request is taken while the block is idle and gives no result
// a tick at or under the speed limit skips the sqrt and divides and goes straight to the rotation
// a tick over the limit first runs the bit-serial sqrt and two 32-step divides
// the next request is taken once the tick's result sits in the output register
// aresetn (synchronous, low) restores default limits and forgets the held command
module velocity_command_limiter_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // cmd_vx, cmd_vy, cmd_wz, rot_xx, rot_xy, rot_yx, rot_yy
    input  logic [vcl_pkg::S_DATA_W-1:0]  s_tdata,
    // action
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // world_vx, world_vy, yaw_rate_out
    output logic [vcl_pkg::M_DATA_W-1:0]  m_tdata,
    // command_stale
    output logic                          m_tuser,
    input  logic                          cfg_we,
    input  logic [vcl_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [vcl_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import vcl_pkg::*;

    localparam logic [CNT_W-1:0] CNT_TOP = '1;

    // configuration
    logic [CFG_DATA_W-1:0] max_lin_reg;
    logic [CFG_DATA_W-1:0] max_yaw_reg;
    logic [TMO_W-1:0]      timeout_reg;

    // held command
    logic [VEL_W-1:0] held_vx_reg, held_vy_reg, held_wz_reg;
    logic [AGE_W-1:0] age_reg;
    logic             seen_reg;

    // sequencer
    logic             busy_reg;
    logic [PC_W-1:0]  pc_reg;
    logic             run_reg;
    logic [CNT_W-1:0] cnt_reg;
    ucode_t           uw;

    // datapath
    logic [VEL_W-1:0] vx_reg, vy_reg, wz_reg, wx_reg;
    logic [ROT_W-1:0] rxx_reg, rxy_reg, ryx_reg, ryy_reg;
    logic             stale_reg;
    logic [63:0]      mul_reg, sum_reg, sq_res_reg;
    logic [VEL_W-1:0] speed_reg, div_rem_reg, div_q_reg;

    // output register
    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_data_reg;
    logic                m_stale_reg;

    logic             s_acc, out_full, out_load, cmd_valid, unit_last, is_unit, step_adv;
    logic [PC_W-1:0]  pc_next;
    logic [VEL_W-1:0] mag_vx, mag_vy;
    logic signed [32:0] op_a, op_b;
    logic signed [65:0] mul_full;
    logic [63:0]      sq_bit, sq_try, sq_n_next, sq_res_next;
    logic             sq_ge;
    logic [32:0]      div_sh, div_diff;
    logic             div_ge, div_neg;
    logic [VEL_W-1:0] div_rem_next, div_q_next, div_res;
    logic signed [32:0] wz_ext, lim_pos, lim_neg;
    logic [VEL_W-1:0] wz_clip;

    assign uw       = ucode_rom(pc_reg);
    assign s_tready = !busy_reg;
    assign s_acc    = s_tvalid && s_tready;
    assign out_full = m_tvalid_reg && !m_tready;
    assign out_load = busy_reg && (uw.act == AC_OUTY) && !out_full;
    assign cmd_valid = seen_reg && (age_reg <= {1'b0, timeout_reg});

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_stale_reg;

    assign is_unit   = (uw.act == AC_SQRT) || (uw.act == AC_DIVX) || (uw.act == AC_DIVY);
    assign unit_last = run_reg && (cnt_reg == '0);

    always_comb begin
        unique case (uw.act)
            AC_SQRT, AC_DIVX, AC_DIVY: step_adv = unit_last;
            AC_OUTY:                   step_adv = !out_full;
            default:                   step_adv = 1'b1;
        endcase
    end

    always_comb begin
        if (uw.act == AC_JLE && sum_reg <= mul_reg) begin
            pc_next = uw.target;
        end else begin
            pc_next = pc_reg + 4'd1;
        end
    end

    // shared multiplier
    assign mag_vx = mag32(vx_reg);
    assign mag_vy = mag32(vy_reg);

    always_comb begin
        unique case (uw.mul_sel)
            MS_VX2: begin op_a = {1'b0, mag_vx}; op_b = {1'b0, mag_vx}; end
            MS_VY2: begin op_a = {1'b0, mag_vy}; op_b = {1'b0, mag_vy}; end
            MS_LL:  begin op_a = {2'b00, max_lin_reg}; op_b = {2'b00, max_lin_reg}; end
            MS_VXL: begin op_a = {1'b0, mag_vx}; op_b = {2'b00, max_lin_reg}; end
            MS_VYL: begin op_a = {1'b0, mag_vy}; op_b = {2'b00, max_lin_reg}; end
            MS_RXX: begin op_a = {{17{rxx_reg[15]}}, rxx_reg}; op_b = {vx_reg[31], vx_reg}; end
            MS_RXY: begin op_a = {{17{rxy_reg[15]}}, rxy_reg}; op_b = {vy_reg[31], vy_reg}; end
            MS_RYX: begin op_a = {{17{ryx_reg[15]}}, ryx_reg}; op_b = {vx_reg[31], vx_reg}; end
            MS_RYY: begin op_a = {{17{ryy_reg[15]}}, ryy_reg}; op_b = {vy_reg[31], vy_reg}; end
            default: begin op_a = '0; op_b = '0; end
        endcase
    end

    assign mul_full = op_a * op_b;

    // square root, one result bit per cycle, remainder kept in sum_reg
    assign sq_bit      = 64'd1 << {cnt_reg, 1'b0};
    assign sq_try      = sq_res_reg + sq_bit;
    assign sq_ge       = sum_reg >= sq_try;
    assign sq_n_next   = sq_ge ? (sum_reg - sq_try) : sum_reg;
    assign sq_res_next = sq_ge ? ((sq_res_reg >> 1) + sq_bit) : (sq_res_reg >> 1);

    // restoring divide; quotient never exceeds the magnitude so 32 steps suffice
    assign div_sh       = {div_rem_reg, div_q_reg[31]};
    assign div_diff     = div_sh - {1'b0, speed_reg};
    assign div_ge       = div_sh >= {1'b0, speed_reg};
    assign div_rem_next = div_ge ? div_diff[31:0] : div_sh[31:0];
    assign div_q_next   = {div_q_reg[30:0], div_ge};
    assign div_neg      = (uw.act == AC_DIVX) ? vx_reg[31] : vy_reg[31];
    assign div_res      = div_neg ? (~div_q_next + 32'd1) : div_q_next;

    // yaw clip
    assign wz_ext  = {wz_reg[31], wz_reg};
    assign lim_pos = {2'b00, max_yaw_reg};
    assign lim_neg = -lim_pos;

    always_comb begin
        if (wz_ext > lim_pos) begin
            wz_clip = lim_pos[31:0];
        end else if (wz_ext < lim_neg) begin
            wz_clip = lim_neg[31:0];
        end else begin
            wz_clip = wz_reg;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_lin_reg  <= MAX_LIN_RESET;
            max_yaw_reg  <= MAX_YAW_RESET;
            timeout_reg  <= TIMEOUT_RESET;
            age_reg      <= '0;
            seen_reg     <= 1'b0;
            busy_reg     <= 1'b0;
            pc_reg       <= '0;
            run_reg      <= 1'b0;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    CFG_MAX_LIN: max_lin_reg <= cfg_wdata;
                    CFG_MAX_YAW: max_yaw_reg <= cfg_wdata;
                    CFG_TIMEOUT: timeout_reg <= cfg_wdata[TMO_W-1:0];
                    default: ;
                endcase
            end

            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            if (s_acc) begin
                if (s_tuser == ACT_COMMAND) begin
                    age_reg  <= '0;
                    seen_reg <= 1'b1;
                end else begin
                    // age saturates, a saturated age is always stale
                    if (age_reg != '1) begin
                        age_reg <= age_reg + 17'd1;
                    end
                    busy_reg <= 1'b1;
                    pc_reg   <= '0;
                    run_reg  <= 1'b0;
                end
            end else if (busy_reg) begin
                if (is_unit) begin
                    if (!run_reg) begin
                        run_reg <= 1'b1;
                        cnt_reg <= CNT_TOP;
                    end else begin
                        cnt_reg <= cnt_reg - 5'd1;
                        if (cnt_reg == '0) begin
                            run_reg <= 1'b0;
                        end
                    end
                end
                if (step_adv) begin
                    pc_reg <= pc_next;
                    if (uw.act == AC_OUTY) begin
                        busy_reg <= 1'b0;
                    end
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            if (s_tuser == ACT_COMMAND) begin
                held_vx_reg <= s_tdata[31:0];
                held_vy_reg <= s_tdata[63:32];
                held_wz_reg <= s_tdata[95:64];
            end else begin
                vx_reg    <= cmd_valid ? held_vx_reg : '0;
                vy_reg    <= cmd_valid ? held_vy_reg : '0;
                wz_reg    <= cmd_valid ? held_wz_reg : '0;
                stale_reg <= !cmd_valid;
                rxx_reg   <= s_tdata[111:96];
                rxy_reg   <= s_tdata[127:112];
                ryx_reg   <= s_tdata[143:128];
                ryy_reg   <= s_tdata[159:144];
            end
        end else if (busy_reg) begin
            mul_reg <= mul_full[63:0];

            unique case (uw.sum_op)
                SO_LOAD: sum_reg <= mul_reg;
                SO_ADD:  sum_reg <= sum_reg + mul_reg;
                default: ;
            endcase

            unique case (uw.act)
                AC_SQRT: begin
                    if (!run_reg) begin
                        sq_res_reg <= '0;
                    end else begin
                        sum_reg    <= sq_n_next;
                        sq_res_reg <= sq_res_next;
                        if (cnt_reg == '0) begin
                            speed_reg <= sq_res_next[31:0];
                        end
                    end
                end
                AC_DIVX, AC_DIVY: begin
                    if (!run_reg) begin
                        div_rem_reg <= mul_reg[63:32];
                        div_q_reg   <= mul_reg[31:0];
                    end else begin
                        div_rem_reg <= div_rem_next;
                        div_q_reg   <= div_q_next;
                        if (cnt_reg == '0) begin
                            if (uw.act == AC_DIVX) begin
                                vx_reg <= div_res;
                            end else begin
                                vy_reg <= div_res;
                            end
                        end
                    end
                end
                AC_CLIP: wz_reg <= wz_clip;
                AC_OUTX: wx_reg <= round_sat(sum_reg);
                AC_OUTY: begin
                    if (!out_full) begin
                        m_data_reg  <= {wz_reg, round_sat(sum_reg), wx_reg};
                        m_stale_reg <= stale_reg;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

@@ rtl/vcl_checker.sv @@
// port-level checks of the velocity command limiter and their binding
module vcl_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [vcl_pkg::M_DATA_W-1:0]  m_tdata,
    input logic                          m_tuser
);
    import vcl_pkg::*;
`include "velocity_command_limiter_unit_assert.svh"

    logic s_acc;
    assign s_acc = s_tvalid && s_tready;

    // a pending result stays until taken
    `VCL_ASSERT_NXT(a_hold_result, m_tvalid && !m_tready, m_tvalid)
    // a command request never produces a result
    `VCL_ASSERT_NXT(a_cmd_silent, s_acc && (s_tuser == ACT_COMMAND) && !m_tvalid, !m_tvalid)
    // a tick occupies the block for at least the next cycle
    `VCL_ASSERT_NXT(a_tick_busy, s_acc && (s_tuser == ACT_TICK), !s_tready)
    // stale command means all velocities zero
    `VCL_ASSERT_IMP(a_stale_zero, m_tvalid && m_tuser, m_tdata == '0)
    // yaw clip range is symmetric, so the most negative value cannot appear
    `VCL_ASSERT_IMP(a_yaw_range, m_tvalid, m_tdata[95:64] != 32'h8000_0000)

endmodule

bind velocity_command_limiter_unit vcl_checker u_vcl_checker (.*);

@@ sim/velocity_command_limiter_checker.sv @@
// checker for the velocity command limiter: mirrors its state, predicts each tick, compares
`timescale 1ns / 100ps
module velocity_command_limiter_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    // cmd_vx, cmd_vy, cmd_wz, rot_xx, rot_xy, rot_yx, rot_yy
    input  logic [vcl_pkg::S_DATA_W-1:0]    s_tdata,
    // action
    input  logic                            s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // world_vx, world_vy, yaw_rate_out
    input  logic [vcl_pkg::M_DATA_W-1:0]    m_tdata,
    // command_stale
    input  logic                            m_tuser,
    input  logic                            cfg_we,
    input  logic [vcl_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [vcl_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output int                              fail_count,
    output int                              motion_pending
);

    localparam logic [vcl_pkg::AGE_W-1:0] AGE_SAT = '1;
    localparam longint Q16_MAX = 64'sh7FFF_FFFF;
    localparam longint Q16_MIN = -64'sh8000_0000;

    typedef struct {
        logic [31:0] world_vx;
        logic [31:0] world_vy;
        logic [31:0] yaw_rate;
        logic        stale;
    } motion_t;

    motion_t motion_due[$];
    int      fails = 0;
    int      pending = 0;

    logic [vcl_pkg::CFG_DATA_W-1:0] lin_limit;
    logic [vcl_pkg::CFG_DATA_W-1:0] yaw_limit;
    logic [vcl_pkg::TMO_W-1:0]      timeout;
    logic signed [31:0]             held_vx, held_vy, held_wz;
    logic [vcl_pkg::AGE_W-1:0]      age;
    logic                           seen;

    assign fail_count     = fails;
    assign motion_pending = pending;

    function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
        logic [63:0] root, probe, rem;
        root  = '0;
        rem   = n;
        probe = 64'd1 << 62;
        while (probe > rem) probe = probe >> 2;
        while (probe != 0) begin
            if (rem >= root + probe) begin
                rem  = rem - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    // component * limit / speed, truncated toward zero
    function automatic longint shrink(input longint v, input logic [63:0] lim,
                                      input logic [63:0] speed);
        logic [63:0] m, q;
        m = (v < 0) ? -v : v;
        q = (m * lim) / speed;
        return (v < 0) ? -longint'(q) : longint'(q);
    endfunction

    // Q18.30 to Q16.16, round half up, saturate
    function automatic logic [31:0] round_q16(input longint acc);
        longint r;
        r = (acc + 8192) >>> 14;
        if (r > Q16_MAX) return 32'h7FFF_FFFF;
        if (r < Q16_MIN) return 32'h8000_0000;
        return r[31:0];
    endfunction

    function automatic motion_t limited_world_motion(input logic [vcl_pkg::S_DATA_W-1:0] data,
                                                     input logic fresh);
        motion_t     r;
        longint      vx, vy, wz, lim;
        longint      rxx, rxy, ryx, ryy;
        logic [63:0] mx, my, sq_sum, lin, speed;
        vx = fresh ? longint'(held_vx) : 0;
        vy = fresh ? longint'(held_vy) : 0;
        wz = fresh ? longint'(held_wz) : 0;
        mx = (vx < 0) ? -vx : vx;
        my = (vy < 0) ? -vy : vy;
        sq_sum = mx * mx + my * my;
        lin = {33'd0, lin_limit};
        if (sq_sum > lin * lin) begin
            speed = floor_sqrt(sq_sum);
            vx = shrink(vx, lin, speed);
            vy = shrink(vy, lin, speed);
        end
        lim = longint'({1'b0, yaw_limit});
        if (wz > lim) wz = lim;
        if (wz < -lim) wz = -lim;
        rxx = longint'($signed(data[111:96]));
        rxy = longint'($signed(data[127:112]));
        ryx = longint'($signed(data[143:128]));
        ryy = longint'($signed(data[159:144]));
        r.world_vx = round_q16(rxx * vx + rxy * vy);
        r.world_vy = round_q16(ryx * vx + ryy * vy);
        r.yaw_rate = wz[31:0];
        r.stale    = !fresh;
        return r;
    endfunction

    always @(posedge aclk) begin : monitor
        motion_t want, got;
        logic    fresh;
        if (!aresetn) begin
            lin_limit = vcl_pkg::MAX_LIN_RESET;
            yaw_limit = vcl_pkg::MAX_YAW_RESET;
            timeout   = vcl_pkg::TIMEOUT_RESET;
            held_vx   = '0;
            held_vy   = '0;
            held_wz   = '0;
            age       = '0;
            seen      = 1'b0;
            motion_due.delete();
        end else begin
            // results leave before this edge's request is predicted
            if (m_tvalid && m_tready) begin
                got.world_vx = m_tdata[31:0];
                got.world_vy = m_tdata[63:32];
                got.yaw_rate = m_tdata[95:64];
                got.stale    = m_tuser;
                if (motion_due.size() == 0) begin
                    if (fails < 10)
                        $display("unexpected result vx=%h vy=%h wz=%h stale=%b",
                                 got.world_vx, got.world_vy, got.yaw_rate, got.stale);
                    fails++;
                end else begin
                    want = motion_due.pop_front();
                    if (got.world_vx != want.world_vx || got.world_vy != want.world_vy ||
                        got.yaw_rate != want.yaw_rate || got.stale != want.stale) begin
                        if (fails < 10)
                            $display("mismatch vx %h/%h vy %h/%h wz %h/%h stale %b/%b (exp/got)",
                                     want.world_vx, got.world_vx, want.world_vy, got.world_vy,
                                     want.yaw_rate, got.yaw_rate, want.stale, got.stale);
                        fails++;
                    end
                end
            end
            if (cfg_we) begin
                case (cfg_addr)
                    vcl_pkg::CFG_MAX_LIN: lin_limit = cfg_wdata;
                    vcl_pkg::CFG_MAX_YAW: yaw_limit = cfg_wdata;
                    vcl_pkg::CFG_TIMEOUT: timeout   = cfg_wdata[vcl_pkg::TMO_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == vcl_pkg::ACT_COMMAND) begin
                    held_vx = s_tdata[31:0];
                    held_vy = s_tdata[63:32];
                    held_wz = s_tdata[95:64];
                    age     = '0;
                    seen    = 1'b1;
                end else begin
                    // age compared before it advances
                    fresh = seen && (age <= {1'b0, timeout});
                    motion_due.push_back(limited_world_motion(s_tdata, fresh));
                    if (age != AGE_SAT) age = age + 1'b1;
                end
            end
        end
        pending = motion_due.size();
    end

endmodule

@@ sim/velocity_command_limiter_unit_tb.sv @@
// testbench top for the velocity command limiter: clock, reset, requests, settings, verdict
`timescale 1ns / 100ps
module velocity_command_limiter_unit_tb;

    import vcl_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN       = 128;
    localparam int LONG_HOLD   = 2000;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic                  s_tuser = ACT_COMMAND;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tuser;
    logic                  cfg_we = 1'b0;
    cfg_idx_t              cfg_addr = CFG_MAX_LIN;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int fail_count;
    int motion_pending;
    int cycles = 0;
    bit steady = 1'b0;

    velocity_command_limiter_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    velocity_command_limiter_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .fail_count     (fail_count),
        .motion_pending (motion_pending)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic int pace();
        return steady ? 0 : int'($urandom_range(0, 14));
    endfunction

    function automatic logic [31:0] pick_velocity();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0;
            3: return 32'($urandom_range(0, 262143)) - 32'd131072;
            4: return 32'($urandom_range(0, 2097151)) - 32'd1048576;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [15:0] pick_rotation();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h4000;
            3: return 16'hC000;
            4: return 16'h0;
            default: return 16'($urandom());
        endcase
    endfunction

    // result side: random hold-offs, plus two long ones to back the block up
    initial begin : result_sink
        int hold, taken;
        taken = 0;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            if (taken == 150 || taken == 900) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
            end
            hold = pace();
            if (hold > 0) begin
                m_tready <= 1'b0;
                repeat (hold) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            taken++;
            @(negedge aclk);
        end
    end

    task automatic push_request(input logic act, input logic [S_DATA_W-1:0] data);
        int gap;
        gap = pace();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= {5{$urandom()}};
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // unused fields of each request kind carry random bits
    task automatic command(input logic [31:0] vx, input logic [31:0] vy, input logic [31:0] wz);
        push_request(ACT_COMMAND, {16'($urandom()), 16'($urandom()), 16'($urandom()),
                                   16'($urandom()), wz, vy, vx});
    endtask

    task automatic tick(input logic [15:0] rxx, input logic [15:0] rxy,
                        input logic [15:0] ryx, input logic [15:0] ryy);
        push_request(ACT_TICK, {ryy, ryx, rxy, rxx, $urandom(), $urandom(), $urandom()});
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (motion_pending != 0) @(negedge aclk);
        repeat (DRAIN) @(negedge aclk);
    endtask

    task automatic set_limits(input logic [30:0] lin, input logic [30:0] yaw,
                              input logic [30:0] tmo);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_MAX_LIN;
        cfg_wdata <= lin;
        @(negedge aclk);
        cfg_addr  <= CFG_MAX_YAW;
        cfg_wdata <= yaw;
        @(negedge aclk);
        cfg_addr  <= CFG_TIMEOUT;
        cfg_wdata <= tmo;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // full-scale commands through full-scale rotations, then a second tick on the same command
    task automatic run_extremes();
        command(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        tick(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        command(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        tick(16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF);
        tick(16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF);
    endtask

    // mostly a command followed by a run of ticks; some runs reuse an old command
    task automatic run_traffic(input int budget, input int max_run);
        int sent, run;
        sent = 0;
        while (sent < budget) begin
            if ($urandom_range(0, 9) != 0) begin
                command(pick_velocity(), pick_velocity(), pick_velocity());
                sent++;
            end
            run = $urandom_range(0, max_run);
            repeat (run) tick(pick_rotation(), pick_rotation(), pick_rotation(), pick_rotation());
            sent += run;
            if ($urandom_range(0, 19) == 0) steady = !steady;
        end
    endtask

    initial begin : stimulus
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset limits: no command yet, exact limit, just over, rounding, quarter turn
        tick(16'h4000, 16'h0, 16'h0, 16'h4000);
        command(32'd65536, 32'd0, 32'd65536);
        tick(16'h4000, 16'h0, 16'h0, 16'h4000);
        command(32'd65537, 32'd0, -32'sd65537);
        tick(16'h4000, 16'h0, 16'h0, 16'h4000);
        run_extremes();
        command(32'd1, -32'sd1, 32'd0);
        tick(16'h2000, 16'h0, 16'h0, 16'h2000);
        tick(16'hE000, 16'h2000, 16'h2000, 16'hE000);
        command(32'd46341, 32'd46341, 32'd12345);
        tick(16'h0, 16'hC000, 16'h4000, 16'h0);
        command(32'd0, 32'd0, 32'd0);
        tick(pick_rotation(), pick_rotation(), pick_rotation(), pick_rotation());
        run_traffic(300, 12);
        settle();

        set_limits(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h0000_FFFF);
        run_extremes();
        run_traffic(350, 12);
        settle();

        // zero timeout: only the first tick after a command is fresh
        set_limits(31'd0, 31'd0, 31'd0);
        run_extremes();
        run_traffic(300, 4);
        settle();

        // upper bits of the timeout write fall outside the register
        set_limits(31'($urandom_range(0, 262143)), 31'($urandom_range(0, 262143)),
                   {15'($urandom()), 16'($urandom_range(0, 20))});
        run_traffic(500, 25);
        settle();

        set_limits(31'($urandom()), 31'($urandom()), 31'($urandom_range(0, 40)));
        run_traffic(450, 45);
        settle();

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
